// ----- rtl/grfd_pkg.sv -----
// ----------------------------------------------------------------------------
// grfd_pkg
// Shared widths, types and codes of the rotation FIFO word decoder.
// ----------------------------------------------------------------------------
package grfd_pkg;

  localparam int FRAC_BITS = 22;

  // signed component width (Q2.F), magnitude / scalar width, square-sum width
  localparam int VW = FRAC_BITS + 2;
  localparam int MW = VW - 1;
  localparam int SW = 2 * MW + 1;
  // square root working width and iteration counter width
  localparam int RW = 2 * FRAC_BITS + 2;
  localparam int CW = $clog2(FRAC_BITS + 1);

  localparam int TAG_W  = 5;
  localparam int HALF_W = 16;

  localparam logic [TAG_W-1:0] ROTATION_TAG_RESET = TAG_W'(19);

  // register index taken from the byte address
  localparam logic [0:0] REG_ROTATION_TAG = 1'b0;

  typedef struct packed {
    logic                 match;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } grfd_item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQX,
    B_SQY,
    B_SQZ,
    B_SUM,
    B_INIT,
    B_ROOT,
    B_SQW,
    B_NORM,
    B_COMMIT
  } back_state_t;

endpackage

// ----- rtl/grfd_front.sv -----
// ----------------------------------------------------------------------------
// grfd_front
// Accepts FIFO words, checks the tag and decodes the three halves to Q2.F.
// ----------------------------------------------------------------------------
module grfd_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [grfd_pkg::TAG_W-1:0]    word_tag,
  input  logic [grfd_pkg::HALF_W-1:0]   half_x,
  input  logic [grfd_pkg::HALF_W-1:0]   half_y,
  input  logic [grfd_pkg::HALF_W-1:0]   half_z,
  input  logic [grfd_pkg::TAG_W-1:0]    rotation_tag,
  output logic                          push_valid,
  input  logic                          push_ready,
  output grfd_pkg::grfd_item_t          push_item
);
  import grfd_pkg::*;

  function automatic logic signed [VW-1:0] half_to_fixed(input logic [HALF_W-1:0] h);
    logic        neg;
    logic [4:0]  ex;
    logic [9:0]  fr;
    logic [63:0] m;
    logic [MW-1:0] mag;
    logic signed [VW-1:0] r;
    int          sh;
    neg = h[15];
    ex  = h[14:10];
    fr  = h[9:0];
    if (ex == 5'd0) begin
      m  = {54'd0, fr};
      sh = FRAC_BITS - 24;
    end else begin
      m  = {53'd0, 1'b1, fr};
      sh = int'(ex) - 25 + FRAC_BITS;
    end
    if (sh >= 0) begin
      m = m << sh;
    end else begin
      m = m >> (-sh);
    end
    mag = m[MW-1:0];
    // infinity, NaN and anything above 1.5 read as zero
    if (ex == 5'h1f || ex > 5'd15 || (ex == 5'd15 && fr > 10'd512)) begin
      mag = '0;
    end
    r = $signed({1'b0, mag});
    if (neg) begin
      r = -r;
    end
    return r;
  endfunction

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_item.match = (word_tag == rotation_tag);
    push_item.x     = half_to_fixed(half_x);
    push_item.y     = half_to_fixed(half_y);
    push_item.z     = half_to_fixed(half_z);
  end

endmodule

// ----- rtl/grfd_queue.sv -----
// ----------------------------------------------------------------------------
// grfd_queue
// Two-entry queue of decoded words between the front and the back.
// ----------------------------------------------------------------------------
module grfd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  grfd_pkg::grfd_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output grfd_pkg::grfd_item_t pop_item
);
  import grfd_pkg::*;

  grfd_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/grfd_back.sv -----
// ----------------------------------------------------------------------------
// grfd_back
// Sequencer: squares through one shared squarer, digit-by-digit square root,
// norm window check, held quaternion and the result register.
// ----------------------------------------------------------------------------
module grfd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  grfd_pkg::grfd_item_t          pop_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [grfd_pkg::MW-1:0]       quat_w,
  output logic signed [grfd_pkg::VW-1:0] quat_x,
  output logic signed [grfd_pkg::VW-1:0] quat_y,
  output logic signed [grfd_pkg::VW-1:0] quat_z,
  output logic                          quat_valid,
  output logic                          word_accepted,
  output logic [31:0]                   accepted_total
);
  import grfd_pkg::*;

  localparam logic [SW-1:0] ONE2      = SW'(1) << (2 * FRAC_BITS);
  localparam logic [SW-1:0] HALF2     = ONE2 >> 1;
  localparam logic [SW-1:0] ONE_HALF2 = ONE2 + HALF2;
  localparam logic [MW-1:0] W_ONE     = MW'(1) << FRAC_BITS;

  back_state_t state;
  back_state_t state_next;

  logic signed [VW-1:0] wx;
  logic signed [VW-1:0] wy;
  logic signed [VW-1:0] wz;
  logic [2*MW-1:0]      prod;
  logic [SW-1:0]        ssum;
  logic [SW-1:0]        n2;
  logic [RW-1:0]        rv;
  logic [RW-1:0]        res;
  logic [RW-1:0]        rbit;
  logic [CW-1:0]        cnt;

  logic [MW-1:0]        held_w;
  logic signed [VW-1:0] held_x;
  logic signed [VW-1:0] held_y;
  logic signed [VW-1:0] held_z;
  logic                 held_valid;
  logic [31:0]          accept_count;

  logic          out_free;
  logic [MW-1:0] sq_op;
  logic          pass_load;
  logic [RW-1:0] trial;
  logic          norm_ok;

  function automatic logic [MW-1:0] mag_of(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] a;
    a = v[VW-1] ? -v : v;
    return a[MW-1:0];
  endfunction

  assign out_free = !out_valid || out_ready;
  assign trial    = res + rbit;
  assign norm_ok  = (n2 > HALF2) && (n2 < ONE_HALF2);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (pop_valid && pop_item.match) state_next = B_SQX;
      B_SQX:    state_next = B_SQY;
      B_SQY:    state_next = B_SQZ;
      B_SQZ:    state_next = B_SUM;
      B_SUM:    state_next = B_INIT;
      B_INIT:   state_next = B_ROOT;
      B_ROOT:   if (cnt == '0) state_next = B_SQW;
      B_SQW:    state_next = B_NORM;
      B_NORM:   state_next = B_COMMIT;
      B_COMMIT: if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_ready = 1'b0;
    pass_load = 1'b0;
    sq_op     = '0;
    unique case (state)
      B_IDLE: begin
        // a mismatched word needs the result slot right away
        pop_ready = pop_item.match || out_free;
        pass_load = pop_valid && !pop_item.match && out_free;
      end
      B_SQX:   sq_op = mag_of(wx);
      B_SQY:   sq_op = mag_of(wy);
      B_SQZ:   sq_op = mag_of(wz);
      B_SQW:   sq_op = res[MW-1:0];
      default: sq_op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= sq_op * sq_op;
    unique case (state)
      B_IDLE: begin
        if (pop_valid && pop_item.match) begin
          wx <= pop_item.x;
          wy <= pop_item.y;
          wz <= pop_item.z;
        end
      end
      B_SQY:  ssum <= {1'b0, prod};
      B_SQZ:  ssum <= ssum + {1'b0, prod};
      B_SUM:  ssum <= ssum + {1'b0, prod};
      B_INIT: begin
        rv   <= (ssum < ONE2) ? RW'(ONE2 - ssum) : '0;
        res  <= '0;
        rbit <= RW'(ONE2);
        cnt  <= CW'(FRAC_BITS);
      end
      B_ROOT: begin
        if (rv >= trial) begin
          rv  <= rv - trial;
          res <= (res >> 1) + rbit;
        end else begin
          res <= res >> 1;
        end
        rbit <= rbit >> 2;
        cnt  <= cnt - CW'(1);
      end
      B_NORM:  n2 <= ssum + {1'b0, prod};
      default: ;
    endcase
  end

  // held quaternion, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_w       <= W_ONE;
      held_x       <= '0;
      held_y       <= '0;
      held_z       <= '0;
      held_valid   <= 1'b0;
      accept_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pass_load || (state == B_COMMIT && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pass_load) begin
        quat_w         <= held_w;
        quat_x         <= held_x;
        quat_y         <= held_y;
        quat_z         <= held_z;
        quat_valid     <= held_valid;
        word_accepted  <= 1'b0;
        accepted_total <= accept_count;
      end
      if (state == B_COMMIT && out_free) begin
        word_accepted <= norm_ok;
        if (norm_ok) begin
          held_w         <= res[MW-1:0];
          held_x         <= wx;
          held_y         <= wy;
          held_z         <= wz;
          held_valid     <= 1'b1;
          accept_count   <= accept_count + 32'd1;
          quat_w         <= res[MW-1:0];
          quat_x         <= wx;
          quat_y         <= wy;
          quat_z         <= wz;
          quat_valid     <= 1'b1;
          accepted_total <= accept_count + 32'd1;
        end else begin
          quat_w         <= held_w;
          quat_x         <= held_x;
          quat_y         <= held_y;
          quat_z         <= held_z;
          quat_valid     <= held_valid;
          accepted_total <= accept_count;
        end
      end
    end
  end

endmodule

// ----- rtl/game_rotation_fifo_decoder_top.sv -----
// ----------------------------------------------------------------------------
// game_rotation_fifo_decoder_top
// Rotation FIFO word decoder: half-float quaternion to Q2.22 with w recovery.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one FIFO word: word_tag and the
//   IEEE half bits of x, y, z. Output channel (out_valid/out_ready) returns
//   one result per word: the held quaternion, its valid flag, whether this
//   word updated it, and the 32-bit accepted count.
//   The APB port holds rotation_tag at byte address 0; only words with that
//   tag are decoded, others just return the held values.
//   Front decodes and tags each word into a two-entry queue; the back takes
//   one word at a time. A mismatched word is taken only while the result
//   register is free and is loaded straight into it. A matching word runs three
//   squares through one shared squarer, a one-bit-per-cycle square root
//   (23 iterations), w squared and the norm check; its result is then
//   committed, and only after that does the back take the next word.
//   Reset restores rotation_tag to 19, w to 1.0, x/y/z, valid and count to
//   zero, and empties the queue. While the receiver stalls the result holds;
//   the back waits, and the queue takes up to two more words before
//   in_ready drops.
// ----------------------------------------------------------------------------
module game_rotation_fifo_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [grfd_pkg::TAG_W-1:0]     word_tag,
  input  logic [grfd_pkg::HALF_W-1:0]    half_x,
  input  logic [grfd_pkg::HALF_W-1:0]    half_y,
  input  logic [grfd_pkg::HALF_W-1:0]    half_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [grfd_pkg::MW-1:0]        quat_w,
  output logic signed [grfd_pkg::VW-1:0] quat_x,
  output logic signed [grfd_pkg::VW-1:0] quat_y,
  output logic signed [grfd_pkg::VW-1:0] quat_z,
  output logic                           quat_valid,
  output logic                           word_accepted,
  output logic [31:0]                    accepted_total
);
  import grfd_pkg::*;

  logic [TAG_W-1:0] rotation_tag;
  logic             push_valid;
  logic             push_ready;
  grfd_item_t       push_item;
  logic             pop_valid;
  logic             pop_ready;
  grfd_item_t       pop_item;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_tag <= ROTATION_TAG_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2:2] == REG_ROTATION_TAG) begin
      rotation_tag <= pwdata[TAG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:2] == REG_ROTATION_TAG) begin
      prdata = {{(32-TAG_W){1'b0}}, rotation_tag};
    end
  end

  grfd_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .word_tag     (word_tag),
    .half_x       (half_x),
    .half_y       (half_y),
    .half_z       (half_z),
    .rotation_tag (rotation_tag),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  grfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  grfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .quat_w         (quat_w),
    .quat_x         (quat_x),
    .quat_y         (quat_y),
    .quat_z         (quat_z),
    .quat_valid     (quat_valid),
    .word_accepted  (word_accepted),
    .accepted_total (accepted_total)
  );

endmodule

// ----- rtl/grfd_checker.sv -----
// ----------------------------------------------------------------------------
// grfd_checker
// Port-level checks of the rotation FIFO word decoder, bound to the top.
// ----------------------------------------------------------------------------
module grfd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [grfd_pkg::MW-1:0]        quat_w,
  input logic signed [grfd_pkg::VW-1:0] quat_x,
  input logic                           quat_valid,
  input logic                           word_accepted,
  input logic [31:0]                    accepted_total
);
  import grfd_pkg::*;

  // a stalled request holds its count
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(accepted_total))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  a_acc_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_accepted |-> quat_valid && accepted_total != 32'd0)
    else $error("accepted word without valid flag or count");

  // nothing accepted yet: reset quaternion and zero count
  a_initial: assert property (@(posedge clk) disable iff (rst)
    out_valid && !quat_valid |->
      accepted_total == 32'd0 && quat_x == '0 && quat_w == (MW'(1) << FRAC_BITS))
    else $error("held values moved before any accepted word");

endmodule

bind game_rotation_fifo_decoder_top grfd_checker u_grfd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .quat_w         (quat_w),
  .quat_x         (quat_x),
  .quat_valid     (quat_valid),
  .word_accepted  (word_accepted),
  .accepted_total (accepted_total)
);
